### src/u2a_pkg.sv
`default_nettype none
package u2a_pkg;

	localparam int unsigned CP_W   = 21;
	localparam int unsigned CHAR_W = 7;
	localparam int unsigned MAX_RES = 4;

	// up to three ascii characters from one folded code point
	typedef struct packed {
		logic [1:0]        n;
		logic [CHAR_W-1:0] c0;
		logic [CHAR_W-1:0] c1;
		logic [CHAR_W-1:0] c2;
	} fold_t;

	// ascii codes used by the folding table
	localparam logic [CHAR_W-1:0] CH_A  = 7'h41;
	localparam logic [CHAR_W-1:0] CH_C  = 7'h43;
	localparam logic [CHAR_W-1:0] CH_E  = 7'h45;
	localparam logic [CHAR_W-1:0] CH_I  = 7'h49;
	localparam logic [CHAR_W-1:0] CH_N  = 7'h4E;
	localparam logic [CHAR_W-1:0] CH_O  = 7'h4F;
	localparam logic [CHAR_W-1:0] CH_U  = 7'h55;
	localparam logic [CHAR_W-1:0] CH_Y  = 7'h59;
	localparam logic [CHAR_W-1:0] CH_LA = 7'h61;
	localparam logic [CHAR_W-1:0] CH_LC = 7'h63;
	localparam logic [CHAR_W-1:0] CH_LE = 7'h65;
	localparam logic [CHAR_W-1:0] CH_LI = 7'h69;
	localparam logic [CHAR_W-1:0] CH_LN = 7'h6E;
	localparam logic [CHAR_W-1:0] CH_LO = 7'h6F;
	localparam logic [CHAR_W-1:0] CH_LS = 7'h73;
	localparam logic [CHAR_W-1:0] CH_LU = 7'h75;
	localparam logic [CHAR_W-1:0] CH_LY = 7'h79;
	localparam logic [CHAR_W-1:0] CH_APOS  = 7'h27;
	localparam logic [CHAR_W-1:0] CH_QUOTE = 7'h22;
	localparam logic [CHAR_W-1:0] CH_DASH  = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT   = 7'h2E;
	localparam logic [CHAR_W-1:0] CH_NUL   = 7'h00;

	function automatic fold_t fold(input logic [CP_W-1:0] cp);
		fold_t f;
		f = '{n: 2'd1, c0: CH_NUL, c1: CH_NUL, c2: CH_NUL};
		unique case (cp)
			21'h0000C0, 21'h0000C1, 21'h0000C2, 21'h0000C3, 21'h0000C4,
			21'h0000C5: f.c0 = CH_A;
			21'h0000E0, 21'h0000E1, 21'h0000E2, 21'h0000E3, 21'h0000E4,
			21'h0000E5: f.c0 = CH_LA;
			21'h0000C6: begin
				f.n = 2'd2; f.c0 = CH_A; f.c1 = CH_E;
			end
			21'h0000E6: begin
				f.n = 2'd2; f.c0 = CH_LA; f.c1 = CH_LE;
			end
			21'h0000C7: f.c0 = CH_C;
			21'h0000E7: f.c0 = CH_LC;
			21'h0000C8, 21'h0000C9, 21'h0000CA, 21'h0000CB: f.c0 = CH_E;
			21'h0000E8, 21'h0000E9, 21'h0000EA, 21'h0000EB: f.c0 = CH_LE;
			21'h0000CC, 21'h0000CD, 21'h0000CE, 21'h0000CF: f.c0 = CH_I;
			21'h0000EC, 21'h0000ED, 21'h0000EE, 21'h0000EF: f.c0 = CH_LI;
			21'h0000D1: f.c0 = CH_N;
			21'h0000F1: f.c0 = CH_LN;
			21'h0000D2, 21'h0000D3, 21'h0000D4, 21'h0000D5, 21'h0000D6,
			21'h0000D8: f.c0 = CH_O;
			21'h0000F2, 21'h0000F3, 21'h0000F4, 21'h0000F5, 21'h0000F6,
			21'h0000F8: f.c0 = CH_LO;
			21'h0000D9, 21'h0000DA, 21'h0000DB, 21'h0000DC: f.c0 = CH_U;
			21'h0000F9, 21'h0000FA, 21'h0000FB, 21'h0000FC: f.c0 = CH_LU;
			21'h0000DD: f.c0 = CH_Y;
			21'h0000FD, 21'h0000FF: f.c0 = CH_LY;
			21'h0000DF: begin
				f.n = 2'd2; f.c0 = CH_LS; f.c1 = CH_LS;
			end
			21'h002018, 21'h002019: f.c0 = CH_APOS;
			21'h00201C, 21'h00201D: f.c0 = CH_QUOTE;
			21'h002013, 21'h002014: f.c0 = CH_DASH;
			21'h002026: begin
				f.n = 2'd3; f.c0 = CH_DOT; f.c1 = CH_DOT; f.c2 = CH_DOT;
			end
			21'h0000B7, 21'h002022: f.c0 = CH_DASH;
			default: f.n = 2'd0;
		endcase
		return f;
	endfunction

endpackage
`default_nettype wire

### src/utf8_to_ascii_transliterator_top.sv
// UTF-8 to ASCII folding decoder. Bytes enter on the s_ side, one word per byte, and a zero
// byte ends the text. Plain ASCII passes through, multi-byte sequences are folded into zero to
// three ASCII characters (accented Latin letters, quotes, dashes, ellipsis), other code points
// and bad bytes are dropped, and a cut-off sequence is folded before the byte that broke it.
// The end of text gives one word with m_tuser high and m_tdata zero. m_tlast marks the final
// word caused by each input byte. A byte is taken every cycle while the result buffer is empty or
// sending its last word; a byte passes the input register and the result buffer before its first
// result word. Its k result words (k <= 4) hold the single output port, which alone sets the sustained rate.
`default_nettype none
module utf8_to_ascii_transliterator_top
	import u2a_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] text_byte
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [6:0] ascii_char, [7] zero fill
	output logic            m_tlast,   // last_of_run
	output logic            m_tuser    // [0] text_end
);

	// input register
	logic            valid_s1;
	logic [7:0]      byte_s1;

	// decoder state
	logic [CP_W-1:0] cp_q;
	logic [1:0]      exp_q;

	// result buffer
	logic [MAX_RES-1:0][CHAR_W-1:0] chars_q;
	logic [2:0]      cnt_q;
	logic [1:0]      idx_q;
	logic            end_q;

	logic            pop;
	logic            pop_last;
	logic            res_free;
	logic            take;

	// decode of the byte in the input register
	logic            is_cont;
	logic [CP_W-1:0] cp_ext;
	logic [1:0]      exp_dec;
	logic [CP_W-1:0] fold_cp;
	fold_t           f;
	logic            do_fold;
	logic            has_extra;
	logic [CHAR_W-1:0] extra_char;
	logic            extra_end;
	logic [MAX_RES-1:0][CHAR_W-1:0] chars_d;
	logic [2:0]      cnt_d;
	logic [2:0]      n0;
	logic [CP_W-1:0] cp_d;
	logic [1:0]      exp_d;

	// output handshake and free slot
	assign pop      = m_tvalid && m_tready;
	assign pop_last = pop && (idx_q == 2'(cnt_q - 3'd1));
	assign res_free = (cnt_q == 3'd0) || pop_last;
	assign take     = valid_s1 && res_free;
	assign s_tready = !valid_s1 || res_free;

	// decode and fold
	always_comb begin
		is_cont    = (byte_s1[7:6] == 2'b10);
		cp_ext     = {cp_q[CP_W-7:0], byte_s1[5:0]};
		exp_dec    = exp_q - 2'd1;
		fold_cp    = cp_q;
		do_fold    = 1'b0;
		has_extra  = 1'b0;
		extra_char = CH_NUL;
		extra_end  = 1'b0;
		cp_d       = '0;
		exp_d      = 2'd0;
		if (exp_q != 2'd0 && is_cont) begin
			fold_cp = cp_ext;
			exp_d   = exp_dec;
			if (exp_dec == 2'd0) begin
				do_fold = 1'b1;
			end else begin
				cp_d = cp_ext;
			end
		end else begin
			// a sequence cut short is folded first
			do_fold = (exp_q != 2'd0);
			priority if (byte_s1 == 8'h00) begin
				has_extra = 1'b1;
				extra_end = 1'b1;
			end else if (byte_s1[7] == 1'b0) begin
				has_extra  = 1'b1;
				extra_char = byte_s1[6:0];
			end else if (byte_s1[7:5] == 3'b110) begin
				cp_d  = CP_W'(byte_s1[4:0]);
				exp_d = 2'd1;
			end else if (byte_s1[7:4] == 4'b1110) begin
				cp_d  = CP_W'(byte_s1[3:0]);
				exp_d = 2'd2;
			end else if (byte_s1[7:3] == 5'b11110) begin
				cp_d  = CP_W'(byte_s1[2:0]);
				exp_d = 2'd3;
			end else begin
				cp_d  = '0;
			end
		end
		f  = fold(fold_cp);
		n0 = do_fold ? {1'b0, f.n} : 3'd0;
		for (int i = 0; i < MAX_RES; i++) begin
			if (3'(i) < n0) begin
				chars_d[i] = (i == 0) ? f.c0 : ((i == 1) ? f.c1 : f.c2);
			end else begin
				chars_d[i] = extra_char;
			end
		end
		cnt_d = n0 + {2'b00, has_extra};
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q  <= '0;
			exp_q <= 2'd0;
		end else if (take) begin
			cp_q  <= cp_d;
			exp_q <= exp_d;
		end
	end

	// result buffer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (take) begin
			cnt_q <= cnt_d;
			idx_q <= 2'd0;
		end else if (pop_last) begin
			cnt_q <= 3'd0;
			idx_q <= 2'd0;
		end else if (pop) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	// result buffer payload
	always_ff @(posedge clk) begin
		if (take) begin
			chars_q <= chars_d;
			end_q   <= extra_end;
		end
	end

	// output word
	assign m_tvalid = (cnt_q != 3'd0);
	assign m_tlast  = (idx_q == 2'(cnt_q - 3'd1));
	assign m_tdata  = {1'b0, chars_q[idx_q]};
	assign m_tuser  = end_q && m_tlast;

endmodule
`default_nettype wire

### src/u2a_checker.sv
`default_nettype none
module u2a_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic       m_tlast,
	input wire logic       m_tuser
);

	// end marker is always the final word of its byte
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tlast)
		else $error("end marker without tlast");

	// end marker carries no character
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 8'h00)
		else $error("end marker with nonzero data");

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
		&& $stable(m_tuser))
		else $error("output word changed while stalled");

	// characters are seven bit ascii; zero appears only in the end marker
	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[7] == 1'b0)
		else $error("output word outside ascii");

endmodule

bind utf8_to_ascii_transliterator_top u2a_checker u_u2a_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);
`default_nettype wire
